// ===== rtl/irlex_pkg.sv =====
// Shared types, character codes and result helpers for the source lexer.
`timescale 1ns / 1ps

package irlex_pkg;

  // Position counters, default width
  localparam int unsigned POSITION_WIDTH = 16;

  // Results one input beat can raise at most, and the queue depth in bundles
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned QUEUE_DEPTH = 2;

  // Input opcodes
  localparam logic OP_SOURCE_BYTE   = 1'b0;
  localparam logic OP_END_OF_SOURCE = 1'b1;

  // Character codes
  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_HASH      = 8'h23;
  localparam logic [7:0] CHAR_COMMA     = 8'h2C;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_COLON     = 8'h3A;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
  localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
  localparam logic [7:0] CHAR_LOWER_T   = 8'h74;

  typedef enum logic [2:0] {
    KIND_CONTENT    = 3'd0,
    KIND_WORD_END   = 3'd1,
    KIND_STRING_END = 3'd2,
    KIND_COMMA      = 3'd3,
    KIND_COLON      = 3'd4,
    KIND_EOL        = 3'd5,
    KIND_EOF        = 3'd6,
    KIND_ERROR      = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE                = 2'd0,
    ERR_UNTERMINATED_STRING = 2'd1,
    ERR_UNTERMINATED_ESCAPE = 2'd2,
    ERR_BAD_ESCAPE          = 2'd3
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  content_byte;
    logic [15:0] pos_line;
    logic [15:0] pos_col;
    err_e        error_code;
    logic        last_of_run;
  } result_t;

  // All results raised by one input beat
  typedef struct packed {
    logic [RES_CNT_W-1:0]         count;
    result_t [MAX_RESULTS-1:0]    res;
  } bundle_t;

  function automatic result_t make_result(input kind_e kind, input logic [7:0] byte_val,
                                          input logic [15:0] line, input logic [15:0] column,
                                          input err_e err);
    result_t r;
    r.kind         = kind;
    r.content_byte = byte_val;
    r.pos_line     = line;
    r.pos_col      = column;
    r.error_code   = err;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

endpackage

// ===== rtl/irlex_front.sv =====
// Lexer front end: takes source beats, tracks position and mode, builds result bundles.
`timescale 1ns / 1ps

module irlex_front #(
  parameter int unsigned PositionWidth = irlex_pkg::POSITION_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [7:0]          data_byte_i,
  output logic                push_o,
  output irlex_pkg::bundle_t  bundle_o,
  input  logic                q_ready_i
);

  typedef logic [PositionWidth-1:0] pos_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_COMMENT,
    MODE_HALTED
  } mode_e;

  localparam pos_t POS_ONE = PositionWidth'(1);

  mode_e mode_q, mode_d;
  logic  slash_q, slash_d;
  logic  eol_q, eol_d;
  pos_t  line_q, line_d, col_q, col_d, sline_q, sline_d, scol_q, scol_d;

  logic                                 in_accept;
  logic                                 go_word, go_idle, clear_v;
  logic [7:0]                           b;
  logic [7:0]                           esc_v;
  logic                                 esc_ok;
  logic [irlex_pkg::RES_CNT_W-1:0]      cnt_v;
  irlex_pkg::result_t [irlex_pkg::MAX_RESULTS-1:0] res_v;

  // Saturating increment
  function automatic pos_t bump(input pos_t v);
    return (&v) ? v : v + POS_ONE;
  endfunction

  function automatic logic [15:0] out_pos(input pos_t v);
    return 16'(v);
  endfunction

  assign in_ready_o = q_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;
  assign b          = data_byte_i;

  always_comb begin
    esc_ok = 1'b1;
    unique case (b)
      irlex_pkg::CHAR_LOWER_N:   esc_v = irlex_pkg::CHAR_LF;
      irlex_pkg::CHAR_LOWER_R:   esc_v = irlex_pkg::CHAR_CR;
      irlex_pkg::CHAR_LOWER_T:   esc_v = irlex_pkg::CHAR_TAB;
      irlex_pkg::CHAR_ZERO:      esc_v = irlex_pkg::CHAR_NUL;
      irlex_pkg::CHAR_BACKSLASH: esc_v = irlex_pkg::CHAR_BACKSLASH;
      irlex_pkg::CHAR_QUOTE:     esc_v = irlex_pkg::CHAR_QUOTE;
      default: begin
        esc_v  = irlex_pkg::CHAR_NUL;
        esc_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    slash_d = slash_q;
    eol_d   = eol_q;
    line_d  = line_q;
    col_d   = col_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    res_v   = '0;
    cnt_v   = '0;
    go_word = 1'b0;
    go_idle = 1'b0;
    clear_v = 1'b0;

    if (in_accept && (opcode_i == irlex_pkg::OP_END_OF_SOURCE)) begin
      clear_v = 1'b1;
      if (mode_q != MODE_HALTED) begin
        if (slash_q) begin
          res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
            irlex_pkg::KIND_CONTENT, irlex_pkg::CHAR_SLASH, out_pos(sline_d), out_pos(scol_d),
            irlex_pkg::ERR_NONE);
          cnt_v   = cnt_v + 1'b1;
          mode_d  = MODE_WORD;
          slash_d = 1'b0;
        end
        if (mode_d == MODE_STRING || mode_d == MODE_ESCAPE) begin
          res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
            irlex_pkg::KIND_ERROR, irlex_pkg::CHAR_NUL, out_pos(sline_d), out_pos(scol_d),
            (mode_d == MODE_STRING) ? irlex_pkg::ERR_UNTERMINATED_STRING
                                    : irlex_pkg::ERR_UNTERMINATED_ESCAPE);
          cnt_v = cnt_v + 1'b1;
        end else begin
          if (mode_d == MODE_WORD) begin
            res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
              irlex_pkg::KIND_WORD_END, irlex_pkg::CHAR_NUL, out_pos(sline_d), out_pos(scol_d),
              irlex_pkg::ERR_NONE);
            cnt_v = cnt_v + 1'b1;
            eol_d = 1'b0;
          end
          if (!eol_d) begin
            res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
              irlex_pkg::KIND_EOL, irlex_pkg::CHAR_NUL, out_pos(line_d), out_pos(col_d),
              irlex_pkg::ERR_NONE);
            cnt_v = cnt_v + 1'b1;
          end
          res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
            irlex_pkg::KIND_EOF, irlex_pkg::CHAR_NUL, out_pos(line_d), out_pos(col_d),
            irlex_pkg::ERR_NONE);
          cnt_v = cnt_v + 1'b1;
        end
      end
    end else if (in_accept && (mode_q != MODE_HALTED)) begin
      if (slash_q) begin
        slash_d = 1'b0;
        if (b == irlex_pkg::CHAR_SLASH) begin
          // Second slash: comment, closing any open word
          if (mode_q == MODE_WORD) begin
            res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
              irlex_pkg::KIND_WORD_END, irlex_pkg::CHAR_NUL, out_pos(sline_d), out_pos(scol_d),
              irlex_pkg::ERR_NONE);
            cnt_v = cnt_v + 1'b1;
            eol_d = 1'b0;
          end
          mode_d = MODE_COMMENT;
          col_d  = bump(col_d);
        end else begin
          res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
            irlex_pkg::KIND_CONTENT, irlex_pkg::CHAR_SLASH, out_pos(sline_d), out_pos(scol_d),
            irlex_pkg::ERR_NONE);
          cnt_v   = cnt_v + 1'b1;
          mode_d  = MODE_WORD;
          go_word = 1'b1;
        end
      end else begin
        unique case (mode_q)
          MODE_WORD: go_word = 1'b1;
          MODE_STRING: begin
            col_d = bump(col_d);
            if (b == irlex_pkg::CHAR_QUOTE) begin
              res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
                irlex_pkg::KIND_STRING_END, irlex_pkg::CHAR_NUL, out_pos(sline_d),
                out_pos(scol_d), irlex_pkg::ERR_NONE);
              cnt_v  = cnt_v + 1'b1;
              eol_d  = 1'b0;
              mode_d = MODE_IDLE;
            end else if (b == irlex_pkg::CHAR_LF) begin
              res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
                irlex_pkg::KIND_ERROR, irlex_pkg::CHAR_NUL, out_pos(sline_d), out_pos(scol_d),
                irlex_pkg::ERR_UNTERMINATED_STRING);
              cnt_v  = cnt_v + 1'b1;
              eol_d  = 1'b0;
              mode_d = MODE_HALTED;
            end else if (b == irlex_pkg::CHAR_BACKSLASH) begin
              mode_d = MODE_ESCAPE;
            end else begin
              res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
                irlex_pkg::KIND_CONTENT, b, out_pos(sline_d), out_pos(scol_d),
                irlex_pkg::ERR_NONE);
              cnt_v = cnt_v + 1'b1;
            end
          end
          MODE_ESCAPE: begin
            col_d = bump(col_d);
            if (esc_ok) begin
              res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
                irlex_pkg::KIND_CONTENT, esc_v, out_pos(sline_d), out_pos(scol_d),
                irlex_pkg::ERR_NONE);
              cnt_v  = cnt_v + 1'b1;
              mode_d = MODE_STRING;
            end else begin
              res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
                irlex_pkg::KIND_ERROR, irlex_pkg::CHAR_NUL, out_pos(sline_d), out_pos(scol_d),
                irlex_pkg::ERR_BAD_ESCAPE);
              cnt_v  = cnt_v + 1'b1;
              eol_d  = 1'b0;
              mode_d = MODE_HALTED;
            end
          end
          MODE_COMMENT: begin
            if (b == irlex_pkg::CHAR_LF) begin
              mode_d  = MODE_IDLE;
              go_idle = 1'b1;
            end else begin
              col_d = bump(col_d);
            end
          end
          default: go_idle = 1'b1;
        endcase
      end

      if (go_word) begin
        if (irlex_pkg::is_blank(b) || b == irlex_pkg::CHAR_COMMA ||
            b == irlex_pkg::CHAR_COLON || b == irlex_pkg::CHAR_HASH) begin
          res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
            irlex_pkg::KIND_WORD_END, irlex_pkg::CHAR_NUL, out_pos(sline_d), out_pos(scol_d),
            irlex_pkg::ERR_NONE);
          cnt_v   = cnt_v + 1'b1;
          eol_d   = 1'b0;
          mode_d  = MODE_IDLE;
          go_idle = 1'b1;
        end else begin
          col_d = bump(col_d);
          if (b == irlex_pkg::CHAR_SLASH) begin
            slash_d = 1'b1;
          end else begin
            res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
              irlex_pkg::KIND_CONTENT, b, out_pos(sline_d), out_pos(scol_d),
              irlex_pkg::ERR_NONE);
            cnt_v = cnt_v + 1'b1;
          end
        end
      end

      if (go_idle) begin
        priority if (b == irlex_pkg::CHAR_CR) begin
          // drop
        end else if (b == irlex_pkg::CHAR_LF) begin
          res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
            irlex_pkg::KIND_EOL, irlex_pkg::CHAR_NUL, out_pos(line_d), out_pos(col_d),
            irlex_pkg::ERR_NONE);
          cnt_v  = cnt_v + 1'b1;
          eol_d  = 1'b1;
          line_d = bump(line_d);
          col_d  = POS_ONE;
        end else if (irlex_pkg::is_blank(b)) begin
          col_d = bump(col_d);
        end else if (b == irlex_pkg::CHAR_SLASH) begin
          sline_d = line_d;
          scol_d  = col_d;
          col_d   = bump(col_d);
          slash_d = 1'b1;
        end else if (b == irlex_pkg::CHAR_HASH) begin
          mode_d = MODE_COMMENT;
          col_d  = bump(col_d);
        end else if (b == irlex_pkg::CHAR_COMMA || b == irlex_pkg::CHAR_COLON) begin
          res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
            (b == irlex_pkg::CHAR_COMMA) ? irlex_pkg::KIND_COMMA : irlex_pkg::KIND_COLON,
            irlex_pkg::CHAR_NUL, out_pos(line_d), out_pos(col_d), irlex_pkg::ERR_NONE);
          cnt_v = cnt_v + 1'b1;
          eol_d = 1'b0;
          col_d = bump(col_d);
        end else begin
          sline_d = line_d;
          scol_d  = col_d;
          col_d   = bump(col_d);
          if (b == irlex_pkg::CHAR_QUOTE) begin
            mode_d = MODE_STRING;
          end else begin
            res_v[cnt_v[irlex_pkg::RES_IDX_W-1:0]] = irlex_pkg::make_result(
              irlex_pkg::KIND_CONTENT, b, out_pos(sline_d), out_pos(scol_d),
              irlex_pkg::ERR_NONE);
            cnt_v  = cnt_v + 1'b1;
            mode_d = MODE_WORD;
          end
        end
      end

      // Any error halts and drops a held slash
      if (mode_d == MODE_HALTED) begin
        slash_d = 1'b0;
      end
    end

    // End of source re-arms everything
    if (clear_v) begin
      mode_d  = MODE_IDLE;
      slash_d = 1'b0;
      eol_d   = 1'b0;
      line_d  = POS_ONE;
      col_d   = POS_ONE;
      sline_d = POS_ONE;
      scol_d  = POS_ONE;
    end

    if (cnt_v != '0) begin
      res_v[irlex_pkg::RES_IDX_W'(cnt_v - 1'b1)].last_of_run = 1'b1;
    end
  end

  assign push_o         = in_accept && (cnt_v != '0);
  assign bundle_o.count = cnt_v;
  assign bundle_o.res   = res_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      slash_q <= 1'b0;
      eol_q   <= 1'b0;
      line_q  <= POS_ONE;
      col_q   <= POS_ONE;
      sline_q <= POS_ONE;
      scol_q  <= POS_ONE;
    end else begin
      mode_q  <= mode_d;
      slash_q <= slash_d;
      eol_q   <= eol_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
    end
  end

endmodule

// ===== rtl/irlex_queue.sv =====
// Short bundle queue between the lexer front end and the result serialiser.
`timescale 1ns / 1ps

module irlex_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  irlex_pkg::bundle_t push_bundle_i,
  output logic               ready_o,
  output logic               valid_o,
  output irlex_pkg::bundle_t head_o,
  input  logic               pop_i
);

  localparam int unsigned PtrW = (irlex_pkg::QUEUE_DEPTH > 1) ?
                                 $clog2(irlex_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(irlex_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(irlex_pkg::QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(irlex_pkg::QUEUE_DEPTH);

  irlex_pkg::bundle_t entries_q [irlex_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign ready_o = (count_q != Full);
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_bundle_i;
    end
  end

endmodule

// ===== rtl/irlex_back.sv =====
// Result serialiser: unpacks bundles one result a beat into the output register.
`timescale 1ns / 1ps

module irlex_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  irlex_pkg::bundle_t q_head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output irlex_pkg::result_t out_o
);

  irlex_pkg::bundle_t                hold_q, hold_d;
  logic [irlex_pkg::RES_CNT_W-1:0]   rem_q, rem_d;
  logic [irlex_pkg::RES_IDX_W-1:0]   idx_q, idx_d;
  logic                              out_valid_q, out_valid_d;
  irlex_pkg::result_t                out_q, out_d;
  logic                              out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    hold_d      = hold_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (out_free) begin
      priority if (rem_q != '0) begin
        // Advance through the held bundle
        out_d       = hold_q.res[idx_q];
        out_valid_d = 1'b1;
        rem_d       = rem_q - 1'b1;
        idx_d       = idx_q + 1'b1;
      end else if (q_valid_i) begin
        // First result goes straight out, hold the rest
        out_d       = q_head_i.res[0];
        out_valid_d = 1'b1;
        hold_d      = q_head_i;
        rem_d       = q_head_i.count - 1'b1;
        idx_d       = irlex_pkg::RES_IDX_W'(1);
        pop_o       = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/ir_source_lexer.sv =====
// Top level of the byte-serial source lexer: front end, bundle queue, serialiser.
`timescale 1ns / 1ps

// Channel  Dir  Handshake                Payload
// -------  ---  -----------------------  ------------------------------------------------
// in       in   in_valid_i/in_ready_o    opcode_i, data_byte_i
// out      out  out_valid_o/out_ready_i  kind_o, content_byte_o, pos_line_o,
//                                        pos_col_o, error_code_o, last_of_run_o
//
// One input beat is taken per cycle while the two-bundle queue has room; the
// front end never waits on the output side directly.
// A beat raising n results (up to four) gives n output beats; the serialiser
// loads one result per cycle, while not stalled, from its held bundle or the queue head.
// The first result of a beat goes through a queue entry and then the output register.
// Reset clears lexer mode, positions and all valid state; there is no clearing pass.
// A stall on out_ready_i backs up into the queue and then drops in_ready_o.

module ir_source_lexer #(
  parameter int unsigned PositionWidth = irlex_pkg::POSITION_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  content_byte_o,
  output logic [15:0] pos_line_o,
  output logic [15:0] pos_col_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);

  // Front end to queue
  logic               push;
  irlex_pkg::bundle_t push_bundle;
  logic               q_ready;

  // Queue to serialiser
  logic               q_valid;
  irlex_pkg::bundle_t q_head;
  logic               pop;

  irlex_pkg::result_t out_res;

  // Classify each beat and build the bundle of results it raises
  irlex_front #(
    .PositionWidth(PositionWidth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .bundle_o    (push_bundle),
    .q_ready_i   (q_ready)
  );

  // Decouple the two halves so either side may stall on its own
  irlex_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_bundle_i (push_bundle),
    .ready_o       (q_ready),
    .valid_o       (q_valid),
    .head_o        (q_head),
    .pop_i         (pop)
  );

  // Hand results out one beat at a time
  irlex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign kind_o         = out_res.kind;
  assign content_byte_o = out_res.content_byte;
  assign pos_line_o     = out_res.pos_line;
  assign pos_col_o      = out_res.pos_col;
  assign error_code_o   = out_res.error_code;
  assign last_of_run_o  = out_res.last_of_run;

endmodule

// ===== rtl/irlex_checker.sv =====
// Port-level checks for the source lexer, bound to the top level.
`timescale 1ns / 1ps

module irlex_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        opcode_i,
  input logic [7:0]  data_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  kind_o,
  input logic [7:0]  content_byte_o,
  input logic [15:0] pos_line_o,
  input logic [15:0] pos_col_o,
  input logic [1:0]  error_code_o,
  input logic        last_of_run_o
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(content_byte_o) && $stable(pos_line_o) && $stable(pos_col_o) &&
      $stable(error_code_o) && $stable(last_of_run_o))
    else $error("output beat changed while stalled");

  // End of file always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == irlex_pkg::KIND_EOF) |-> last_of_run_o)
    else $error("end of file not last of run");

  // An error always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == irlex_pkg::KIND_ERROR) |-> last_of_run_o)
    else $error("error not last of run");

  // Error code only on error beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != irlex_pkg::KIND_ERROR) |-> error_code_o == irlex_pkg::ERR_NONE)
    else $error("error code on a non-error beat");

  // Content byte only on content beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != irlex_pkg::KIND_CONTENT) |-> content_byte_o == irlex_pkg::CHAR_NUL)
    else $error("content byte on a non-content beat");

endmodule

bind ir_source_lexer irlex_checker u_checker (.*);

// ===== dv/irlex_token_checker.sv =====
// Token checker for the source lexer: predicts every input beat and compares each result beat.
`timescale 1ns / 1ps

module irlex_token_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        opcode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  content_byte_i,
  input  logic [15:0] pos_line_i,
  input  logic [15:0] pos_col_i,
  input  logic [1:0]  error_code_i,
  input  logic        last_of_run_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [2:0] {
    LEX_IDLE,
    LEX_WORD,
    LEX_STRING,
    LEX_ESCAPE,
    LEX_COMMENT,
    LEX_HALTED
  } lex_mode_e;

  localparam logic [15:0] POS_LIMIT = 16'hFFFF;

  lex_mode_e   lex_mode;
  logic        slash_held;
  logic        after_eol;
  logic [15:0] cur_line;
  logic [15:0] cur_col;
  logic [15:0] tok_line;
  logic [15:0] tok_col;

  irlex_pkg::result_t beat_tokens[$];
  irlex_pkg::result_t expected_tokens[$];
  int                 mismatch_total = 0;

  assign fail_count_o = mismatch_total;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == POS_LIMIT) ? v : v + 16'd1;
  endfunction

  function automatic logic blank_char(input logic [7:0] b);
    return (b == irlex_pkg::CHAR_SPACE) ||
           ((b >= irlex_pkg::CHAR_TAB) && (b <= irlex_pkg::CHAR_CR));
  endfunction

  function automatic void reset_lexer();
    lex_mode   = LEX_IDLE;
    slash_held = 1'b0;
    after_eol  = 1'b0;
    cur_line   = 16'd1;
    cur_col    = 16'd1;
    tok_line   = 16'd1;
    tok_col    = 16'd1;
  endfunction

  // Drop anything past the per-beat maximum
  function automatic void emit_token(input irlex_pkg::kind_e k, input logic [7:0] b,
                                     input logic [15:0] ln, input logic [15:0] col,
                                     input irlex_pkg::err_e e);
    irlex_pkg::result_t r;
    if (beat_tokens.size() >= irlex_pkg::MAX_RESULTS) return;
    r.kind         = k;
    r.content_byte = b;
    r.pos_line     = ln;
    r.pos_col      = col;
    r.error_code   = e;
    r.last_of_run  = 1'b0;
    beat_tokens.insert(beat_tokens.size(), r);
    if (k != irlex_pkg::KIND_CONTENT) after_eol = (k == irlex_pkg::KIND_EOL);
  endfunction

  function automatic void mark_start();
    tok_line = cur_line;
    tok_col  = cur_col;
  endfunction

  function automatic void raise_error(input irlex_pkg::err_e code);
    emit_token(irlex_pkg::KIND_ERROR, 8'h00, tok_line, tok_col, code);
    lex_mode   = LEX_HALTED;
    slash_held = 1'b0;
  endfunction

  function automatic void idle_char(input logic [7:0] b);
    if (b == irlex_pkg::CHAR_CR) return;
    if (b == irlex_pkg::CHAR_LF) begin
      emit_token(irlex_pkg::KIND_EOL, 8'h00, cur_line, cur_col, irlex_pkg::ERR_NONE);
      cur_line = sat_inc(cur_line);
      cur_col  = 16'd1;
      return;
    end
    if (blank_char(b)) begin
      cur_col = sat_inc(cur_col);
      return;
    end
    if (b == irlex_pkg::CHAR_SLASH) begin
      mark_start();
      cur_col    = sat_inc(cur_col);
      slash_held = 1'b1;
      return;
    end
    if (b == irlex_pkg::CHAR_HASH) begin
      lex_mode = LEX_COMMENT;
      cur_col  = sat_inc(cur_col);
      return;
    end
    if ((b == irlex_pkg::CHAR_COMMA) || (b == irlex_pkg::CHAR_COLON)) begin
      if (b == irlex_pkg::CHAR_COMMA)
        emit_token(irlex_pkg::KIND_COMMA, 8'h00, cur_line, cur_col, irlex_pkg::ERR_NONE);
      else
        emit_token(irlex_pkg::KIND_COLON, 8'h00, cur_line, cur_col, irlex_pkg::ERR_NONE);
      cur_col = sat_inc(cur_col);
      return;
    end
    mark_start();
    cur_col = sat_inc(cur_col);
    if (b == irlex_pkg::CHAR_QUOTE) begin
      lex_mode = LEX_STRING;
      return;
    end
    emit_token(irlex_pkg::KIND_CONTENT, b, tok_line, tok_col, irlex_pkg::ERR_NONE);
    lex_mode = LEX_WORD;
  endfunction

  function automatic void word_char(input logic [7:0] b);
    if (blank_char(b) || (b == irlex_pkg::CHAR_COMMA) || (b == irlex_pkg::CHAR_COLON) ||
        (b == irlex_pkg::CHAR_HASH)) begin
      emit_token(irlex_pkg::KIND_WORD_END, 8'h00, tok_line, tok_col, irlex_pkg::ERR_NONE);
      lex_mode = LEX_IDLE;
      idle_char(b);
      return;
    end
    cur_col = sat_inc(cur_col);
    if (b == irlex_pkg::CHAR_SLASH) begin
      slash_held = 1'b1;
      return;
    end
    emit_token(irlex_pkg::KIND_CONTENT, b, tok_line, tok_col, irlex_pkg::ERR_NONE);
  endfunction

  function automatic void string_char(input logic [7:0] b);
    cur_col = sat_inc(cur_col);
    if (b == irlex_pkg::CHAR_QUOTE) begin
      emit_token(irlex_pkg::KIND_STRING_END, 8'h00, tok_line, tok_col, irlex_pkg::ERR_NONE);
      lex_mode = LEX_IDLE;
    end else if (b == irlex_pkg::CHAR_LF) begin
      raise_error(irlex_pkg::ERR_UNTERMINATED_STRING);
    end else if (b == irlex_pkg::CHAR_BACKSLASH) begin
      lex_mode = LEX_ESCAPE;
    end else begin
      emit_token(irlex_pkg::KIND_CONTENT, b, tok_line, tok_col, irlex_pkg::ERR_NONE);
    end
  endfunction

  function automatic void escape_char(input logic [7:0] b);
    logic [7:0] decoded;
    cur_col = sat_inc(cur_col);
    case (b)
      irlex_pkg::CHAR_LOWER_N:   decoded = irlex_pkg::CHAR_LF;
      irlex_pkg::CHAR_LOWER_R:   decoded = irlex_pkg::CHAR_CR;
      irlex_pkg::CHAR_LOWER_T:   decoded = irlex_pkg::CHAR_TAB;
      irlex_pkg::CHAR_ZERO:      decoded = irlex_pkg::CHAR_NUL;
      irlex_pkg::CHAR_BACKSLASH: decoded = irlex_pkg::CHAR_BACKSLASH;
      irlex_pkg::CHAR_QUOTE:     decoded = irlex_pkg::CHAR_QUOTE;
      default: begin
        raise_error(irlex_pkg::ERR_BAD_ESCAPE);
        return;
      end
    endcase
    emit_token(irlex_pkg::KIND_CONTENT, decoded, tok_line, tok_col, irlex_pkg::ERR_NONE);
    lex_mode = LEX_STRING;
  endfunction

  function automatic void source_char(input logic [7:0] b);
    if (lex_mode == LEX_HALTED) return;
    if (slash_held) begin
      slash_held = 1'b0;
      if (b == irlex_pkg::CHAR_SLASH) begin
        if (lex_mode == LEX_WORD)
          emit_token(irlex_pkg::KIND_WORD_END, 8'h00, tok_line, tok_col, irlex_pkg::ERR_NONE);
        lex_mode = LEX_COMMENT;
        cur_col  = sat_inc(cur_col);
        return;
      end
      emit_token(irlex_pkg::KIND_CONTENT, irlex_pkg::CHAR_SLASH, tok_line, tok_col,
                 irlex_pkg::ERR_NONE);
      lex_mode = LEX_WORD;
      word_char(b);
      return;
    end
    case (lex_mode)
      LEX_WORD:   word_char(b);
      LEX_STRING: string_char(b);
      LEX_ESCAPE: escape_char(b);
      LEX_COMMENT: begin
        if (b == irlex_pkg::CHAR_LF) begin
          lex_mode = LEX_IDLE;
          idle_char(b);
        end else begin
          cur_col = sat_inc(cur_col);
        end
      end
      default:    idle_char(b);
    endcase
  endfunction

  function automatic void close_source();
    if (lex_mode == LEX_HALTED) begin
      reset_lexer();
      return;
    end
    if (slash_held) begin
      emit_token(irlex_pkg::KIND_CONTENT, irlex_pkg::CHAR_SLASH, tok_line, tok_col,
                 irlex_pkg::ERR_NONE);
      lex_mode   = LEX_WORD;
      slash_held = 1'b0;
    end
    if (lex_mode == LEX_STRING) begin
      raise_error(irlex_pkg::ERR_UNTERMINATED_STRING);
      reset_lexer();
      return;
    end
    if (lex_mode == LEX_ESCAPE) begin
      raise_error(irlex_pkg::ERR_UNTERMINATED_ESCAPE);
      reset_lexer();
      return;
    end
    if (lex_mode == LEX_WORD)
      emit_token(irlex_pkg::KIND_WORD_END, 8'h00, tok_line, tok_col, irlex_pkg::ERR_NONE);
    if (!after_eol)
      emit_token(irlex_pkg::KIND_EOL, 8'h00, cur_line, cur_col, irlex_pkg::ERR_NONE);
    emit_token(irlex_pkg::KIND_EOF, 8'h00, cur_line, cur_col, irlex_pkg::ERR_NONE);
    reset_lexer();
  endfunction

  // Work out the tokens of one input beat and queue them, last one flagged
  function automatic void predict_tokens(input logic op, input logic [7:0] b);
    int n;
    beat_tokens.delete();
    if (op == irlex_pkg::OP_END_OF_SOURCE) close_source();
    else source_char(b);
    n = beat_tokens.size();
    if (n > 0) beat_tokens[n-1].last_of_run = 1'b1;
    foreach (beat_tokens[i]) expected_tokens.insert(expected_tokens.size(), beat_tokens[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_total++;
    $display("[%0t] token check: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic check_token();
    irlex_pkg::result_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch("result beat with nothing expected, kind", 32'(kind_i), 32'd0);
      return;
    end
    want = expected_tokens.pop_front();
    if (kind_i !== want.kind) report_mismatch("kind", 32'(kind_i), 32'(want.kind));
    if (content_byte_i !== want.content_byte)
      report_mismatch("content_byte", 32'(content_byte_i), 32'(want.content_byte));
    if (pos_line_i !== want.pos_line)
      report_mismatch("pos_line", 32'(pos_line_i), 32'(want.pos_line));
    if (pos_col_i !== want.pos_col)
      report_mismatch("pos_col", 32'(pos_col_i), 32'(want.pos_col));
    if (error_code_i !== want.error_code)
      report_mismatch("error_code", 32'(error_code_i), 32'(want.error_code));
    if (last_of_run_i !== want.last_of_run)
      report_mismatch("last_of_run", 32'(last_of_run_i), 32'(want.last_of_run));
  endtask

  // Results never come out in the cycle their input beat is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_lexer();
      expected_tokens.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_token();
      if (in_valid_i && in_ready_i) predict_tokens(opcode_i, data_byte_i);
      pending_o <= expected_tokens.size();
    end
  end

endmodule

// ===== dv/ir_source_lexer_tb.sv =====
// Testbench top for the source lexer: stimulus, receiver stalls, timeout and verdict.
`timescale 1ns / 1ps

module ir_source_lexer_tb;

  // A run is a couple of hundred beats. A beat raises at most four results; the
  // limit leaves ample room behind the sparsest receiver pattern plus the longest
  // sender gap before calling it hung.
  localparam int CYCLE_LIMIT = 50_000;
  localparam int RANDOM_BEATS = 125;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = irlex_pkg::OP_SOURCE_BYTE;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  content_byte;
  logic [15:0] pos_line;
  logic [15:0] pos_col;
  logic [1:0]  error_code;
  logic        last_of_run;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          beats_sent = 0;
  int          burst_left = 0;

  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  pattern_step = 4'd0;

  always #4 clk = ~clk;

  ir_source_lexer uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .content_byte_o (content_byte),
    .pos_line_o     (pos_line),
    .pos_col_o      (pos_col),
    .error_code_o   (error_code),
    .last_of_run_o  (last_of_run)
  );

  irlex_token_checker u_token_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .opcode_i       (opcode),
    .data_byte_i    (data_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .kind_i         (kind),
    .content_byte_i (content_byte),
    .pos_line_i     (pos_line),
    .pos_col_i      (pos_col),
    .error_code_i   (error_code),
    .last_of_run_i  (last_of_run),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Receiver: reload a fresh 16-bit ready pattern each time round. Some patterns
  // are solid ready, some dense, some sparse enough to back the queue up and drop
  // in_ready, so stalls land on every phase of a multi-result beat.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      pattern_step <= 4'd0;
    end else begin
      pattern_step <= pattern_step + 4'd1;
      if (pattern_step == 4'd0) begin
        case ($urandom_range(0, 3))
          0:       ready_pattern <= 16'hFFFF;
          1:       ready_pattern <= 16'($urandom | $urandom);
          2:       ready_pattern <= 16'($urandom & $urandom);
          default: ready_pattern <= 16'($urandom);
        endcase
      end
      out_ready <= ready_pattern[pattern_step];
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one beat and hold it until taken. The sender works in bursts: when a
  // burst runs out, drop valid for a random gap, mostly short, now and then long
  // enough for the block to drain completely.
  task automatic send_beat(input logic op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      burst_left = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(irlex_pkg::OP_SOURCE_BYTE, s[i]);
  endtask

  // End of source carries no character; put junk on the byte lines anyway
  task automatic end_source();
    send_beat(irlex_pkg::OP_END_OF_SOURCE, 8'($urandom_range(0, 255)));
  endtask

  // Word content: letters mostly, with digits, quotes, slashes and high bytes
  function automatic logic [7:0] pick_word_char();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(128, 255));
      1:       return irlex_pkg::CHAR_SLASH;
      2:       return irlex_pkg::CHAR_QUOTE;
      3:       return 8'($urandom_range(8'h30, 8'h39));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  function automatic logic [7:0] pick_escape_letter();
    case ($urandom_range(0, 5))
      0:       return irlex_pkg::CHAR_LOWER_N;
      1:       return irlex_pkg::CHAR_LOWER_R;
      2:       return irlex_pkg::CHAR_LOWER_T;
      3:       return irlex_pkg::CHAR_ZERO;
      4:       return irlex_pkg::CHAR_BACKSLASH;
      default: return irlex_pkg::CHAR_QUOTE;
    endcase
  endfunction

  // One piece of string body: a legal escape, a high byte or printable text
  task automatic send_string_piece();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: begin
        send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_BACKSLASH);
        send_beat(irlex_pkg::OP_SOURCE_BYTE, pick_escape_letter());
      end
      1: send_beat(irlex_pkg::OP_SOURCE_BYTE, 8'($urandom_range(128, 255)));
      default: begin
        b = 8'($urandom_range(8'h20, 8'h7E));
        if ((b == irlex_pkg::CHAR_QUOTE) || (b == irlex_pkg::CHAR_BACKSLASH)) b = 8'h78;
        send_beat(irlex_pkg::OP_SOURCE_BYTE, b);
      end
    endcase
  endtask

  // A source of a few tokens with random content, closed by end of source. Most
  // sources are well formed; now and then one breaks a string and halts the lexer.
  task automatic random_source();
    int         tokens;
    int         n;
    bit         broke;
    logic [7:0] b;
    tokens = $urandom_range(2, 10);
    broke  = 1'b0;
    for (int t = 0; t < tokens && !broke; t++) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3: begin
          n = $urandom_range(1, 4);
          repeat (n) send_beat(irlex_pkg::OP_SOURCE_BYTE, pick_word_char());
        end
        4, 5, 6: begin
          send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_QUOTE);
          n = $urandom_range(0, 4);
          repeat (n) send_string_piece();
          send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_QUOTE);
        end
        7:  send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_COMMA);
        8:  send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_COLON);
        9: begin
          case ($urandom_range(0, 4))
            0:       send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_SPACE);
            1:       send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_TAB);
            2:       send_beat(irlex_pkg::OP_SOURCE_BYTE, 8'h0B);
            3:       send_beat(irlex_pkg::OP_SOURCE_BYTE, 8'h0C);
            default: send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_CR);
          endcase
        end
        10: begin
          if ($urandom_range(0, 1) == 0)
            send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_CR);
          send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_LF);
        end
        11: begin
          if ($urandom_range(0, 1) == 0)
            send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_HASH);
          else send_text("//");
          n = $urandom_range(0, 3);
          repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (b == irlex_pkg::CHAR_LF) b = irlex_pkg::CHAR_SPACE;
            send_beat(irlex_pkg::OP_SOURCE_BYTE, b);
          end
          send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_LF);
        end
        12: send_beat(irlex_pkg::OP_SOURCE_BYTE, 8'($urandom_range(0, 255)));
        13: send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_SLASH);
        14: begin
          send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_QUOTE);
          case ($urandom_range(0, 3))
            0: begin
              // unsupported escape
              b = 8'($urandom_range(0, 255));
              if ((b == irlex_pkg::CHAR_LOWER_N) || (b == irlex_pkg::CHAR_LOWER_R) ||
                  (b == irlex_pkg::CHAR_LOWER_T) || (b == irlex_pkg::CHAR_ZERO) ||
                  (b == irlex_pkg::CHAR_BACKSLASH) || (b == irlex_pkg::CHAR_QUOTE))
                b = 8'h71;
              send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_BACKSLASH);
              send_beat(irlex_pkg::OP_SOURCE_BYTE, b);
            end
            1: send_text("a\n");
            2: send_text("ab");
            default: send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_BACKSLASH);
          endcase
          // bytes after a halt must raise nothing
          n = $urandom_range(0, 2);
          repeat (n) send_beat(irlex_pkg::OP_SOURCE_BYTE, 8'($urandom_range(0, 255)));
          broke = 1'b1;
        end
        default: send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_SPACE);
      endcase
      if ($urandom_range(0, 2) == 0) send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_SPACE);
    end
    end_source();
  endtask

  initial begin
    int random_goal;

    // Hold reset, then release it away from the rising edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Quote inside a word, lone slash turned into content, a double slash that
    // closes the open word, a hash inside the comment and a dropped carriage return
    send_text("w\"/q//#");
    send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_CR);
    send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_LF);
    end_source();

    // All six string escapes, colon and comma, the byte extremes as a word, then
    // a slash still pending at end of source: that beat raises four results
    send_text("\"\\n\\r\\t\\0\\\\\\\"\":,");
    send_beat(irlex_pkg::OP_SOURCE_BYTE, 8'h00);
    send_beat(irlex_pkg::OP_SOURCE_BYTE, 8'hFF);
    send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_TAB);
    send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_SLASH);
    end_source();

    // Unsupported escape, a byte ignored while halted, then the silent re-arm
    send_text("\"a\\q");
    send_beat(irlex_pkg::OP_SOURCE_BYTE, 8'h7A);
    end_source();

    // Newline inside a string, end of source inside a string and after a backslash
    send_text("\"\n");
    end_source();
    send_beat(irlex_pkg::OP_SOURCE_BYTE, irlex_pkg::CHAR_QUOTE);
    end_source();
    send_text("\"\\");
    end_source();

    // Random sources until enough beats have gone in
    random_goal = beats_sent + RANDOM_BEATS;
    while (beats_sent < random_goal) random_source();
    in_valid <= 1'b0;

    // Drain: wait for every predicted result, then wait on for strays
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
